// ===== hw/rtl/b64e_pkg.sv =====
// package for the base64 stream encoder
// holds the group word type, queue sizing and the alphabet lookup; no dependencies
package b64e_pkg;

    // bytes per group and characters per group
    localparam int GROUP_BYTES = 3;
    localparam int GROUP_CHARS = 4;

    // group queue depth between the front and back parts
    localparam int QUEUE_DEPTH = 2;

    // six-bit mask and pad character
    localparam logic [5:0] SEXTET_MASK = 6'h3F;
    localparam logic [6:0] PAD_CHAR    = 7'h3D;

    // one assembled group waiting to be expanded into characters
    typedef struct packed {
        logic [23:0] bits;   // first byte in 23..16, missing bytes are zero
        logic [1:0]  held;   // real bytes in the group, 1 to 3
        logic        last;   // group ends the message
    } t_group;

    // queue status seen by the front and back parts
    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    // map one sextet to its ascii code in the standard alphabet
    function automatic logic [6:0] sextet_to_char(input logic [5:0] v);
        logic [6:0] c;
        case (v) inside
            [6'd0:6'd25]:  c = 7'h41 + {1'b0, v};
            [6'd26:6'd51]: c = 7'h61 + {1'b0, v} - 7'd26;
            [6'd52:6'd61]: c = 7'h30 + {1'b0, v} - 7'd52;
            6'd62:         c = 7'h2B;
            default:       c = 7'h2F;
        endcase
        return c;
    endfunction

endpackage

// ===== hw/rtl/b64e_front.sv =====
// front part: takes input words, gathers bytes into groups of three
// depends on b64e_pkg for the group type
module b64e_front (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  logic [7:0]             i_data_byte,
    input  logic                   i_last_byte,
    input  b64e_pkg::t_queue_status i_queue_status,
    output logic                   o_stall,
    output logic                   o_push,
    output b64e_pkg::t_group       o_group
);

    logic [15:0] r_group_bytes;
    logic [15:0] n_group_bytes;
    logic [1:0]  r_pos;
    logic [1:0]  n_pos;
    logic [1:0]  pos;
    logic        accept;
    logic        ends_group;

    // hold off input while the queue cannot take a group
    assign o_stall = i_queue_status.full;
    assign accept  = i_valid && !o_stall;

    // an impossible position counts as the start of a group
    assign pos        = (r_pos == 2'd3) ? 2'd0 : r_pos;
    assign ends_group = (pos == 2'd2) || i_last_byte;

    // gather bytes and form the outgoing group
    always_comb begin
        n_group_bytes = r_group_bytes;
        n_pos         = r_pos;
        if (pos == 2'd0) begin
            n_group_bytes = {i_data_byte, 8'h00};
        end else if (pos == 2'd1) begin
            n_group_bytes = {r_group_bytes[15:8], i_data_byte};
        end
        if (accept) begin
            n_pos = ends_group ? 2'd0 : pos + 2'd1;
        end
        o_group.last = i_last_byte;
        o_group.held = pos + 2'd1;
        if (pos == 2'd2) begin
            o_group.bits = {r_group_bytes, i_data_byte};
        end else begin
            o_group.bits = {n_group_bytes, 8'h00};
        end
    end

    assign o_push = accept && ends_group;

    // group state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos         <= 2'd0;
            r_group_bytes <= 16'h0000;
        end else begin
            r_pos <= n_pos;
            if (accept) begin
                r_group_bytes <= n_group_bytes;
            end
        end
    end

endmodule

// ===== hw/rtl/b64e_queue.sv =====
// short group queue between the front and back parts
// depends on b64e_pkg for the group type and depth
module b64e_queue (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_push,
    input  b64e_pkg::t_group        i_group,
    input  logic                    i_pop,
    output b64e_pkg::t_group        o_head,
    output b64e_pkg::t_queue_status o_status
);

    localparam int PTR_W = (b64e_pkg::QUEUE_DEPTH > 1) ? $clog2(b64e_pkg::QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(b64e_pkg::QUEUE_DEPTH + 1);

    b64e_pkg::t_group r_mem [b64e_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] r_wr_ptr;
    logic [PTR_W-1:0] r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             do_push;
    logic             do_pop;

    assign o_status.full  = (r_count == CNT_W'(b64e_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_count == '0);
    assign do_push        = i_push && !o_status.full;
    assign do_pop         = i_pop && !o_status.empty;
    assign o_head         = r_mem[r_rd_ptr];

    // entry storage
    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_group;
        end
    end

    // pointers and fill count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PTR_W'(b64e_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PTR_W'(b64e_pkg::QUEUE_DEPTH - 1)) ? '0
                                                                             : r_rd_ptr + 1'b1;
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + 1'b1;
            end else if (do_pop && !do_push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

endmodule

// ===== hw/rtl/b64e_back.sv =====
// back part: expands each queued group into four characters, one per word
// depends on b64e_pkg for the group type and the alphabet function
module b64e_back (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  b64e_pkg::t_group        i_head,
    input  b64e_pkg::t_queue_status i_queue_status,
    output logic                    o_pop,
    input  logic                    i_stall,
    output logic                    o_valid,
    output logic [6:0]              o_out_char,
    output logic                    o_last_char
);

    logic [1:0] r_idx;
    logic       r_valid;
    logic [6:0] r_char;
    logic       r_last;
    logic       load;
    logic       take;
    logic [5:0] sextet;
    logic       pad;
    logic [6:0] n_char;

    // output register is free when empty or being taken
    assign load  = !r_valid || !i_stall;
    assign take  = load && !i_queue_status.empty;
    assign o_pop = take && (r_idx == 2'd3);

    // pick the sextet for the current character slot
    always_comb begin
        case (r_idx)
            2'd0:    sextet = i_head.bits[23:18];
            2'd1:    sextet = i_head.bits[17:12];
            2'd2:    sextet = i_head.bits[11:6];
            default: sextet = i_head.bits[5:0] & b64e_pkg::SEXTET_MASK;
        endcase
        pad    = ((r_idx == 2'd2) && (i_head.held < 2'd2)) ||
                 ((r_idx == 2'd3) && (i_head.held < 2'd3));
        n_char = pad ? b64e_pkg::PAD_CHAR : b64e_pkg::sextet_to_char(sextet);
    end

    // slot counter and output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= 2'd0;
            r_valid <= 1'b0;
        end else if (load) begin
            r_valid <= !i_queue_status.empty;
            if (take) begin
                r_idx <= r_idx + 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (take) begin
            r_char <= n_char;
            r_last <= i_head.last && (r_idx == 2'd3);
        end
    end

    assign o_valid     = r_valid;
    assign o_out_char  = r_char;
    assign o_last_char = r_last;

endmodule

// ===== hw/rtl/base64_stream_encoder.sv =====
// top level of the base64 stream encoder
// instantiates b64e_front, b64e_queue and b64e_back; depends on b64e_pkg
//
// Streaming base64 encoder with the standard alphabet. One raw byte is taken
// per input word, with i_last_byte marking the end of a message; every group
// of three bytes, or a shorter final group padded with '=', becomes four
// ascii characters on the output, one per word, the last one flagged by
// o_last_char. Input bytes are taken one per cycle while the two-entry group
// queue has room; the output side emits one character per cycle while
// i_stall is low and a group is queued, so the sustained input rate is set
// by the one-wide character output. A final short group still yields four
// output characters. A group that is closed is registered in the queue, and
// its first character then in the output register.
module base64_stream_encoder_core (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    output logic       o_stall,
    input  logic [7:0] i_data_byte,
    input  logic       i_last_byte,
    output logic       o_valid,
    input  logic       i_stall,
    output logic [6:0] o_out_char,
    output logic       o_last_char
);

    b64e_pkg::t_group        push_group;
    b64e_pkg::t_group        head_group;
    b64e_pkg::t_queue_status queue_status;
    logic                    push;
    logic                    pop;

    // byte gathering
    b64e_front u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (i_valid),
        .i_data_byte    (i_data_byte),
        .i_last_byte    (i_last_byte),
        .i_queue_status (queue_status),
        .o_stall        (o_stall),
        .o_push         (push),
        .o_group        (push_group)
    );

    // group queue
    b64e_queue u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (push),
        .i_group  (push_group),
        .i_pop    (pop),
        .o_head   (head_group),
        .o_status (queue_status)
    );

    // character expansion
    b64e_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_head         (head_group),
        .i_queue_status (queue_status),
        .o_pop          (pop),
        .i_stall        (i_stall),
        .o_valid        (o_valid),
        .o_out_char     (o_out_char),
        .o_last_char    (o_last_char)
    );

    // queue is never full and empty at once
    a_queue_flags : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(queue_status.full && queue_status.empty))
        else $error("queue flags both set");

    // a pushed group leaves the queue non-empty in the next cycle
    a_push_lands : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        push |=> !queue_status.empty)
        else $error("pushed group lost");

    // a flagged final character is always the pad or an alphabet character
    a_last_char_code : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_last_char) |-> (o_out_char == b64e_pkg::PAD_CHAR ||
            o_out_char == 7'h2B || o_out_char == 7'h2F || o_out_char >= 7'h30))
        else $error("bad final character");

    // reset leaves no character on the output
    a_reset_clear : assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("output valid after reset");

endmodule

// ===== tb/b64e_checker.sv =====
`timescale 1ns / 100ps
// checker for the base64 stream encoder: watches both channels, predicts characters
// from accepted bytes and compares them in order; depends on b64e_pkg
module b64e_checker (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_in_valid,
    input  logic       i_in_stall,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_last,
    input  logic       i_out_valid,
    input  logic       i_out_stall,
    input  logic [6:0] i_out_char,
    input  logic       i_out_last,
    input  logic       i_drain_done,
    output int         o_fail_count,
    output int         o_pending
);

    // one predicted output word
    typedef struct packed {
        logic [6:0] ch;
        logic       last;
    } t_b64_char;

    // standard alphabet, index 0 in the top byte
    localparam logic [511:0] ALPHABET_BITS =
        "ABCDEFGHIJKLMNOPQRSTUVWXYZabcdefghijklmnopqrstuvwxyz0123456789+/";

    t_b64_char   char_queue [$];
    logic [15:0] group_hold;
    logic [1:0]  group_pos;
    int          fail_total;
    logic        drain_seen;

    initial begin
        fail_total   = 0;
        drain_seen   = 1'b0;
        group_hold   = '0;
        group_pos    = '0;
    end

    function automatic logic [6:0] sextet_char(input logic [5:0] v);
        logic [7:0] c;
        c = ALPHABET_BITS[8 * (63 - v) +: 8];
        return c[6:0];
    endfunction

    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $time, msg);
        fail_total++;
    endtask

    task automatic push_char(input logic [6:0] ch, input logic last);
        t_b64_char e;
        e.ch   = ch;
        e.last = last;
        char_queue.push_back(e);
    endtask

    // fold one byte into the pending group, emit four characters when it closes
    task automatic encode_byte(input logic [7:0] b, input logic last);
        logic [23:0] grp;
        logic [1:0]  pos;
        int          nbytes;
        pos = (group_pos == 2'd3) ? 2'd0 : group_pos;
        if (pos == 2'd0) begin
            group_hold = {b, 8'h00};
        end else if (pos == 2'd1) begin
            group_hold[7:0] = b;
        end
        if (pos < 2'd2 && !last) begin
            group_pos = pos + 2'd1;
            return;
        end
        if (pos == 2'd2) begin
            grp    = {group_hold, b};
            nbytes = 3;
        end else begin
            grp    = {group_hold, 8'h00};
            nbytes = pos + 1;
        end
        push_char(sextet_char(grp[23:18]), 1'b0);
        push_char(sextet_char(grp[17:12]), 1'b0);
        push_char((nbytes >= 2) ? sextet_char(grp[11:6]) : b64e_pkg::PAD_CHAR, 1'b0);
        push_char((nbytes >= 3) ? sextet_char(grp[5:0]) : b64e_pkg::PAD_CHAR, last);
        group_pos = 2'd0;
    endtask

    // sample both channels at the edge where words move
    always @(posedge i_clk) begin
        t_b64_char exp_char;
        if (i_rst_n) begin
            if (i_in_valid && !i_in_stall) begin
                encode_byte(i_in_byte, i_in_last);
            end
            if (i_out_valid && !i_out_stall) begin
                if (char_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected char 0x%02h last %0b",
                                              i_out_char, i_out_last));
                end else begin
                    exp_char = char_queue.pop_front();
                    if (i_out_char !== exp_char.ch) begin
                        report_mismatch($sformatf("char got 0x%02h want 0x%02h",
                                                  i_out_char, exp_char.ch));
                    end
                    if (i_out_last !== exp_char.last) begin
                        report_mismatch($sformatf("last_char got %0b want %0b (char 0x%02h)",
                                                  i_out_last, exp_char.last, exp_char.ch));
                    end
                end
            end
            // anything still queued once the stream has drained is missing
            if (i_drain_done && !drain_seen) begin
                drain_seen = 1'b1;
                if (char_queue.size() != 0) begin
                    report_mismatch($sformatf("%0d chars never arrived", char_queue.size()));
                end
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= char_queue.size();
    end

endmodule

// ===== tb/tb_base64_stream_encoder_core.sv =====
`timescale 1ns / 100ps
// testbench top for base64_stream_encoder_core: byte stimulus, output pacing and verdict
// depends on the encoder rtl, b64e_pkg and b64e_checker
module tb_base64_stream_encoder_core;

    localparam int TOTAL_WORDS  = 420;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int LONG_HOLD    = 60;
    localparam int DRAIN_CYCLES = 10;

    logic       i_clk;
    logic       i_rst_n;
    logic       i_valid;
    logic       o_stall;
    logic [7:0] i_data_byte;
    logic       i_last_byte;
    logic       o_valid;
    logic       i_stall;
    logic [6:0] o_out_char;
    logic       o_last_char;

    logic drain_done;
    int   fail_count;
    int   pending_chars;
    int   words_sent;
    int   cycle_count;

    // pacing controls, changed at clock edges by the byte process
    logic tx_gaps_on;
    logic rx_stalls_on;
    logic long_hold_req;

    // directed words as {last, byte}: "Man", "M", "Ma", all-zero and all-one
    // groups, lone 0xff, short 00 ff, and a "++++" group followed by a lone zero
    logic [8:0] directed_words [19] = '{
        9'h04D, 9'h061, 9'h16E,
        9'h14D,
        9'h04D, 9'h161,
        9'h000, 9'h000, 9'h000, 9'h0FF, 9'h0FF, 9'h1FF,
        9'h1FF,
        9'h000, 9'h1FF,
        9'h0FB, 9'h0EF, 9'h0BE, 9'h100
    };

    base64_stream_encoder_core u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_out_char  (o_out_char),
        .o_last_char (o_last_char)
    );

    b64e_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_valid),
        .i_in_stall   (o_stall),
        .i_in_byte    (i_data_byte),
        .i_in_last    (i_last_byte),
        .i_out_valid  (o_valid),
        .i_out_stall  (i_stall),
        .i_out_char   (o_out_char),
        .i_out_last   (o_last_char),
        .i_drain_done (drain_done),
        .o_fail_count (fail_count),
        .o_pending    (pending_chars)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // offer one byte, with an optional idle burst first, and wait until it is taken
    task automatic send_word(input logic [7:0] b, input logic last);
        if (tx_gaps_on && $urandom_range(0, 3) == 0) begin
            i_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge i_clk);
        end
        i_valid     <= 1'b1;
        i_data_byte <= b;
        i_last_byte <= last;
        do @(posedge i_clk); while (o_stall);
        words_sent++;
    endtask

    // one message of random bytes, mostly short, sometimes long
    task automatic send_message();
        int len;
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 40) : $urandom_range(1, 9);
        for (int i = 0; i < len; i++) begin
            send_word(8'($urandom_range(0, 255)), i == len - 1);
        end
    endtask

    // output side pacing: random stall bursts, plus one long hold on request
    initial begin
        int  n;
        logic hold_done;
        hold_done = 1'b0;
        i_stall  <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (long_hold_req && !hold_done) begin
                hold_done = 1'b1;
                i_stall <= 1'b1;
                repeat (LONG_HOLD) @(posedge i_clk);
                i_stall <= 1'b0;
            end else if (rx_stalls_on && $urandom_range(0, 5) == 0) begin
                n = $urandom_range(1, 5);
                i_stall <= 1'b1;
                repeat (n) @(posedge i_clk);
                i_stall <= 1'b0;
            end
        end
    end

    // run limit
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("simulation failed");
        $finish;
    end

    // reset, byte stimulus by phase, drain and verdict
    initial begin
        i_rst_n       <= 1'b0;
        i_valid       <= 1'b0;
        i_data_byte   <= 8'h00;
        i_last_byte   <= 1'b0;
        drain_done    <= 1'b0;
        tx_gaps_on    <= 1'b1;
        rx_stalls_on  <= 1'b1;
        long_hold_req <= 1'b0;
        words_sent    = 0;
        repeat (5) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed corner cases
        foreach (directed_words[i]) begin
            send_word(directed_words[i][7:0], directed_words[i][8]);
        end

        // random messages, idling on both sides
        while (words_sent < 150) send_message();

        // back-to-back bytes against a long output hold
        tx_gaps_on    <= 1'b0;
        long_hold_req <= 1'b1;
        while (words_sent < 190) send_message();

        // output stalls only, then input gaps only
        rx_stalls_on <= 1'b1;
        while (words_sent < 260) send_message();
        tx_gaps_on   <= 1'b1;
        rx_stalls_on <= 1'b0;
        while (words_sent < 330) send_message();

        // quiet tail at full rate
        tx_gaps_on   <= 1'b0;
        rx_stalls_on <= 1'b0;
        while (words_sent < TOTAL_WORDS) send_message();
        i_valid <= 1'b0;

        // wait for every predicted char, then a little longer
        do @(posedge i_clk); while (pending_chars != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        drain_done <= 1'b1;
        repeat (2) @(posedge i_clk);

        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
